/* rtl/xtef_pkg.sv */
`timescale 1ns / 1ps
// xtef_pkg: shared types, constants and byte tables of the xml text escape filter
// no dependencies; compiled first

package xtef_pkg;

  // default for the exception slot limit
  localparam int MAX_EXC_DEF = 4;

  // register indexes on the configuration port
  localparam logic [2:0] REG_FILTER_MODE = 3'd0;
  localparam logic [2:0] REG_IS_LYRIC    = 3'd1;
  localparam logic [2:0] REG_IS_PHRASE   = 3'd2;
  localparam logic [2:0] REG_MAX_LENGTH  = 3'd3;
  localparam logic [2:0] REG_EXC_CHARS   = 3'd4;
  localparam logic [2:0] REG_EXC_COUNT   = 3'd5;

  // filter modes
  localparam logic [2:0] MODE_FOLD     = 3'd0;
  localparam logic [2:0] MODE_ASCII    = 3'd1;
  localparam logic [2:0] MODE_ASCII_NS = 3'd2;
  localparam logic [2:0] MODE_EXT      = 3'd3;

  // queue between classifier and emitter
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [2:0] {
    ENT_NONE,
    ENT_QUOT,
    ENT_APOS,
    ENT_LT,
    ENT_GT,
    ENT_AMP
  } xtef_ent_t;

  typedef struct packed {
    logic [2:0]  filter_mode;
    logic        is_lyric;
    logic        is_phrase;
    logic [7:0]  max_length;
    logic [31:0] exc_chars;
    logic [2:0]  exc_count;
  } xtef_cfg_t;

  // one classified item waiting for the emitter
  typedef struct packed {
    logic       kept;
    logic [7:0] chr;
    xtef_ent_t  ent;
    logic       last;
  } xtef_entry_t;

  // accent folding; full adds the longer table
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic full);
    logic [7:0] v;
    v = c;
    if (c == 8'd142) v = "Z";
    else if (c inside {8'd159, 8'd221}) v = "Y";
    else if (c inside {8'd255, 8'd253}) v = "y";
    else if (c == 8'd195) v = "A";
    else if (c == 8'd227) v = "a";
    else if (c == 8'd205) v = "I";
    else if (c == 8'd213) v = "O";
    else if (c == 8'd245) v = "o";
    else if (full) begin
      if (c inside {8'd192, 8'd193, 8'd194, 8'd196, 8'd197}) v = "A";
      else if (c inside {8'd224, 8'd225, 8'd226, 8'd228, 8'd229}) v = "a";
      else if (c == 8'd199) v = "C";
      else if (c == 8'd231) v = "c";
      else if (c inside {[8'd200:8'd203]}) v = "E";
      else if (c inside {[8'd232:8'd235]}) v = "e";
      else if (c inside {8'd204, 8'd206, 8'd207}) v = "I";
      else if (c inside {[8'd236:8'd239]}) v = "i";
      else if (c == 8'd209) v = "N";
      else if (c == 8'd241) v = "n";
      else if (c inside {8'd210, 8'd211, 8'd212, 8'd214, 8'd216}) v = "O";
      else if (c inside {8'd242, 8'd243, 8'd244, 8'd246, 8'd248}) v = "o";
      else if (c inside {[8'd217:8'd220]}) v = "U";
      else if (c == 8'd138) v = "S";
      else if (c inside {[8'd249:8'd252]}) v = "u";
      else if (c == 8'd154) v = "s";
      else if (c == 8'd158) v = "z";
    end
    return v;
  endfunction

  // extended allow table
  function automatic logic ext_allowed(input logic [7:0] c);
    return c inside {[8'd33:8'd95], [8'd97:8'd126], 8'd128, [8'd132:8'd133], 8'd138,
                     8'd140, [8'd145:8'd146], [8'd153:8'd154], 8'd156, 8'd158,
                     [8'd161:8'd162], [8'd165:8'd168], [8'd170:8'd171], 8'd176,
                     [8'd178:8'd180], [8'd182:8'd194], [8'd196:8'd204],
                     [8'd206:8'd207], [8'd209:8'd212], 8'd214, [8'd216:8'd220],
                     [8'd222:8'd226], [8'd228:8'd239], [8'd241:8'd244], 8'd246,
                     [8'd248:8'd252]};
  endfunction

  function automatic logic [2:0] ent_len(input xtef_ent_t e);
    logic [2:0] n;
    case (e)
      ENT_NONE: n = 3'd1;
      ENT_QUOT: n = 3'd6;
      ENT_APOS: n = 3'd6;
      ENT_LT:   n = 3'd4;
      ENT_GT:   n = 3'd4;
      ENT_AMP:  n = 3'd5;
      default:  n = 3'd1;
    endcase
    return n;
  endfunction

  // byte k of an entity, left aligned text
  function automatic logic [7:0] ent_byte(input xtef_ent_t e, input logic [2:0] k);
    logic [47:0] s;
    logic [7:0]  b;
    case (e)
      ENT_QUOT: s = "&quot;";
      ENT_APOS: s = "&apos;";
      ENT_LT:   s = {"&lt;", 16'h0000};
      ENT_GT:   s = {"&gt;", 16'h0000};
      ENT_AMP:  s = {"&amp;", 8'h00};
      default:  s = 48'h0;
    endcase
    case (k)
      3'd0:    b = s[47:40];
      3'd1:    b = s[39:32];
      3'd2:    b = s[31:24];
      3'd3:    b = s[23:16];
      3'd4:    b = s[15:8];
      3'd5:    b = s[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* rtl/xtef_if.sv */
`timescale 1ns / 1ps
// xtef_in_if / xtef_out_if: valid-ready channels of the escape filter
// no dependencies

interface xtef_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       string_end;

  modport source (output valid, char_in, string_end, input ready);
  modport sink (input valid, char_in, string_end, output ready);
endinterface

interface xtef_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       string_done;
  logic       truncated;

  modport source (output valid, out_byte, byte_valid, run_last, string_done, truncated,
                  input ready);
  modport sink (input valid, out_byte, byte_valid, run_last, string_done, truncated,
                output ready);
endinterface

/* rtl/xml_text_escape_filter.sv */
`timescale 1ns / 1ps
// xml_text_escape_filter: top level, configuration registers and the three parts
// depends on xtef_pkg, xtef_if, xtef_classify, xtef_queue, xtef_emit

// Streams a string one byte per input item and returns its XML-escaped form at most one byte
// per result item. The front end classifies each item in the cycle it is accepted
// (exception match, accent folding, mode filter, entity choice) and writes it into a
// four-entry queue; the back end pops the queue, applies the length limit and walks
// the entity bytes into a registered output stage. Items that keep one plain byte flow
// at one per cycle while the receiver is ready; an entity yields four to six results,
// the item at string_end adds a closing result, and a dropped byte still passes
// through the back end with no result. The emitter's single output register is what
// limits the rate. Registers are written through cfg_we/cfg_index/cfg_wdata and must
// only change while idle.
module xml_text_escape_filter #(
  parameter int MAX_EXCEPTIONS = xtef_pkg::MAX_EXC_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  xtef_in_if.sink     in_ch,
  xtef_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import xtef_pkg::*;

  xtef_cfg_t   cfg_r, cfg_nxt;
  xtef_entry_t q_wdata, q_rdata;
  logic        q_push, q_pop, q_rvalid, q_full;

  // register writes, unknown indexes ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_MODE: cfg_nxt.filter_mode = cfg_wdata[2:0];
        REG_IS_LYRIC:    cfg_nxt.is_lyric    = cfg_wdata[0];
        REG_IS_PHRASE:   cfg_nxt.is_phrase   = cfg_wdata[0];
        REG_MAX_LENGTH:  cfg_nxt.max_length  = cfg_wdata[7:0];
        REG_EXC_CHARS:   cfg_nxt.exc_chars   = cfg_wdata;
        REG_EXC_COUNT:   cfg_nxt.exc_count   = cfg_wdata[2:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_mode <= MODE_ASCII_NS;
      cfg_r.is_lyric    <= 1'b1;
      cfg_r.is_phrase   <= 1'b0;
      cfg_r.max_length  <= 8'd48;
      cfg_r.exc_chars   <= 32'd0;
      cfg_r.exc_count   <= 3'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front end: accept and classify
  xtef_classify #(
    .MAX_EXCEPTIONS(MAX_EXCEPTIONS)
  ) u_classify (
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .push   (q_push),
    .entry  (q_wdata)
  );

  // decoupling queue
  xtef_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .rvalid (q_rvalid),
    .full   (q_full)
  );

  // back end: length check, expansion, output stage
  xtef_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (q_rdata),
    .head_valid (q_rvalid),
    .head_pop   (q_pop),
    .out_ch     (out_ch)
  );

endmodule

/* rtl/xtef_classify.sv */
`timescale 1ns / 1ps
// xtef_classify: front end, accepts input items, filters, folds, picks the entity
// depends on xtef_pkg and xtef_in_if

module xtef_classify #(
  parameter int MAX_EXCEPTIONS = xtef_pkg::MAX_EXC_DEF
) (
  xtef_in_if.sink              in_ch,
  input  xtef_pkg::xtef_cfg_t   cfg,
  input  logic                  q_full,
  output logic                  push,
  output xtef_pkg::xtef_entry_t entry
);
  import xtef_pkg::*;

  localparam int EXC_LIM = (MAX_EXCEPTIONS < 4) ? MAX_EXCEPTIONS : 4;

  logic       exc_hit;
  logic       keep;
  logic [7:0] v;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    exc_hit = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (i < EXC_LIM && i < int'(cfg.exc_count) &&
          cfg.exc_chars[8*i +: 8] == in_ch.char_in) begin
        exc_hit = 1'b1;
      end
    end
  end

  always_comb begin
    v    = in_ch.char_in;
    keep = 1'b1;
    if (!exc_hit) begin
      if (cfg.filter_mode == MODE_FOLD || cfg.filter_mode == MODE_ASCII ||
          cfg.filter_mode == MODE_ASCII_NS) begin
        v = fold_byte(in_ch.char_in, 1'b1);
        if (v < 8'd32 || v > 8'd126) keep = 1'b0;
        else if (cfg.filter_mode != MODE_FOLD) begin
          if (cfg.filter_mode == MODE_ASCII_NS && v == "/") keep = 1'b0;
          if (!cfg.is_lyric && (v inside {"(", ")", "{", "}", ",", "\\", ":", "\""}))
            keep = 1'b0;
          if (cfg.is_phrase &&
              !(v inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}))
            keep = 1'b0;
        end
      end else if (cfg.filter_mode == MODE_EXT) begin
        v    = fold_byte(in_ch.char_in, 1'b0);
        keep = ext_allowed(v);
      end
    end
  end

  always_comb begin
    entry.kept = keep;
    entry.chr  = v;
    entry.last = in_ch.string_end;
    if (v == "\"") entry.ent = ENT_QUOT;
    else if (v == "'") entry.ent = ENT_APOS;
    else if (v == "<") entry.ent = ENT_LT;
    else if (v == ">") entry.ent = ENT_GT;
    else if (v == "&") entry.ent = ENT_AMP;
    else entry.ent = ENT_NONE;
  end

endmodule

/* rtl/xtef_queue.sv */
`timescale 1ns / 1ps
// xtef_queue: short queue of classified items between front and back
// depends on xtef_pkg

module xtef_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  xtef_pkg::xtef_entry_t wdata,
  input  logic                  pop,
  output xtef_pkg::xtef_entry_t rdata,
  output logic                  rvalid,
  output logic                  full
);
  import xtef_pkg::*;

  xtef_entry_t       mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]     count_r, count_nxt;

  assign rdata  = mem_r[rd_ptr_r];
  assign rvalid = count_r != '0;
  assign full   = count_r == (Q_AW+1)'(Q_DEPTH);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* rtl/xtef_emit.sv */
`timescale 1ns / 1ps
// xtef_emit: back end, length check, entity expansion, closing result, output register
// depends on xtef_pkg and xtef_out_if

module xtef_emit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  xtef_pkg::xtef_cfg_t   cfg,
  input  xtef_pkg::xtef_entry_t head,
  input  logic                  head_valid,
  output logic                  head_pop,
  xtef_out_if.source            out_ch
);
  import xtef_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  logic       go_r, go_nxt;
  logic [7:0] be_r, be_nxt;
  logic       stopped_r, stopped_nxt;

  logic       ov_r, ov_nxt;
  logic [7:0] obyte_r, obyte_nxt;
  logic       obv_r, obv_nxt;
  logic       olast_r, olast_nxt;
  logic       odone_r, odone_nxt;
  logic       otrunc_r, otrunc_nxt;

  logic       first, fits, stop_set, go, is_byte, last_res, out_free, step;
  logic [2:0] len, nbytes, total;

  always_comb begin
    first    = idx_r == 3'd0;
    len      = ent_len(head.ent);
    fits     = ({1'b0, be_r} + 9'(len) + 9'd1) <= {1'b0, cfg.max_length};
    stop_set = first && head.kept && !stopped_r && !fits;
    go       = first ? (head.kept && !stopped_r && fits) : go_r;
    nbytes   = go ? len : 3'd0;
    total    = nbytes + {2'b00, head.last};
    is_byte  = idx_r < nbytes;
    last_res = (idx_r + 3'd1) == total;
    out_free = !ov_r || out_ch.ready;
    step     = head_valid && (total == 3'd0 || out_free);
    head_pop = step && (total == 3'd0 || last_res);
  end

  always_comb begin
    idx_nxt     = idx_r;
    go_nxt      = go_r;
    be_nxt      = be_r;
    stopped_nxt = stopped_r;
    ov_nxt      = ov_r && !out_ch.ready;
    obyte_nxt   = obyte_r;
    obv_nxt     = obv_r;
    olast_nxt   = olast_r;
    odone_nxt   = odone_r;
    otrunc_nxt  = otrunc_r;
    if (step) begin
      idx_nxt = head_pop ? 3'd0 : idx_r + 3'd1;
      if (first) begin
        go_nxt      = go;
        be_nxt      = be_r + {5'd0, nbytes};
        stopped_nxt = stopped_r || stop_set;
      end
      if (head_pop && head.last) begin
        be_nxt      = 8'd0;
        stopped_nxt = 1'b0;
      end
      if (total != 3'd0) begin
        ov_nxt     = 1'b1;
        obv_nxt    = is_byte;
        olast_nxt  = last_res;
        odone_nxt  = !is_byte;
        otrunc_nxt = !is_byte && (stopped_r || stop_set);
        if (!is_byte) obyte_nxt = 8'h00;
        else if (head.ent == ENT_NONE) obyte_nxt = head.chr;
        else obyte_nxt = ent_byte(head.ent, idx_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= 3'd0;
      go_r      <= 1'b0;
      be_r      <= 8'd0;
      stopped_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      idx_r     <= idx_nxt;
      go_r      <= go_nxt;
      be_r      <= be_nxt;
      stopped_r <= stopped_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obyte_r  <= obyte_nxt;
    obv_r    <= obv_nxt;
    olast_r  <= olast_nxt;
    odone_r  <= odone_nxt;
    otrunc_r <= otrunc_nxt;
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.out_byte    = obyte_r;
  assign out_ch.byte_valid  = obv_r;
  assign out_ch.run_last    = olast_r;
  assign out_ch.string_done = odone_r;
  assign out_ch.truncated   = otrunc_r;

  // partway through an item's results, that item stays at the queue head
  a_mid_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 3'd0 |-> head_valid)
    else $error("sequence index set without a queued item");

  // closing result carries no byte and ends its item's run
  a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && odone_r |-> !obv_r && olast_r)
    else $error("closing result malformed");

  // truncation flag only on a closing result
  a_trunc_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && otrunc_r |-> odone_r)
    else $error("truncated set on a byte result");

  // no item yields more than seven results
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= 3'd6)
    else $error("sequence index out of range");

endmodule

/* bench/tb_xml_text_escape_filter.sv */
`timescale 1ns / 1ps
// tb_xml_text_escape_filter: self-checking bench for the xml text escape filter
// depends on xtef_pkg, xtef_in_if / xtef_out_if and the xml_text_escape_filter rtl

module tb_xml_text_escape_filter;
  import xtef_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 6;
  // four queued items of up to seven results each, plus the output stage
  localparam int DRAIN_CYCLES = 48;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_SHOWN    = 10;
  localparam int EXC_SLOTS    = MAX_EXC_DEF;

  // modes four and up all pass bytes through unfiltered
  localparam logic [2:0] MODE_RAW     = 3'd4;
  localparam logic [2:0] MODE_RAW_TOP = 3'd7;

  // one escaped output item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_done;
    logic       truncated;
  } escaped_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  xtef_in_if  in_ch ();
  xtef_out_if out_ch ();

  xml_text_escape_filter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // predictor copy of the registers and the per-string state
  logic [2:0]  m_mode;
  logic        m_lyric;
  logic        m_phrase;
  logic [7:0]  m_max_len;
  logic [31:0] m_exc_chars;
  logic [2:0]  m_exc_count;
  int          m_emitted;
  logic        m_stopped;

  escaped_t escaped_q[$];
  int       fail_count  = 0;
  int       idle_cycles = 0;

  // traffic shaping knobs
  bit   tx_calm = 1'b0;
  bit   rx_calm = 1'b0;
  bit   rx_hold = 1'b0;
  event hold_start;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // accent folding; the short table always applies, the long one only when full
  function automatic logic [7:0] fold_accent(input logic [7:0] c, input logic full);
    case (c)
      8'd142:         return "Z";
      8'd159, 8'd221: return "Y";
      8'd255, 8'd253: return "y";
      8'd195:         return "A";
      8'd227:         return "a";
      8'd205:         return "I";
      8'd213:         return "O";
      8'd245:         return "o";
      default: ;
    endcase
    if (!full) return c;
    case (c)
      8'd192, 8'd193, 8'd194, 8'd196, 8'd197: return "A";
      8'd224, 8'd225, 8'd226, 8'd228, 8'd229: return "a";
      8'd199:                                 return "C";
      8'd231:                                 return "c";
      8'd200, 8'd201, 8'd202, 8'd203:         return "E";
      8'd232, 8'd233, 8'd234, 8'd235:         return "e";
      8'd204, 8'd206, 8'd207:                 return "I";
      8'd236, 8'd237, 8'd238, 8'd239:         return "i";
      8'd209:                                 return "N";
      8'd241:                                 return "n";
      8'd210, 8'd211, 8'd212, 8'd214, 8'd216: return "O";
      8'd242, 8'd243, 8'd244, 8'd246, 8'd248: return "o";
      8'd217, 8'd218, 8'd219, 8'd220:         return "U";
      8'd138:                                 return "S";
      8'd249, 8'd250, 8'd251, 8'd252:         return "u";
      8'd154:                                 return "s";
      8'd158:                                 return "z";
      default: ;
    endcase
    return c;
  endfunction

  // extended mode allow list, inclusive ranges
  function automatic logic ext_table_hit(input logic [7:0] c);
    return c inside {[8'd33:8'd95], [8'd97:8'd126], 8'd128, [8'd132:8'd133], 8'd138,
                     8'd140, [8'd145:8'd146], [8'd153:8'd154], 8'd156, 8'd158,
                     [8'd161:8'd162], [8'd165:8'd168], [8'd170:8'd171], 8'd176,
                     [8'd178:8'd180], [8'd182:8'd194], [8'd196:8'd204],
                     [8'd206:8'd207], [8'd209:8'd212], 8'd214, [8'd216:8'd220],
                     [8'd222:8'd226], [8'd228:8'd239], [8'd241:8'd244], 8'd246,
                     [8'd248:8'd252]};
  endfunction

  function automatic logic is_alnum_byte(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // decides whether a raw byte survives; c gets the byte after folding
  function automatic logic filter_keeps(input logic [7:0] raw, output logic [7:0] c);
    int slots;
    c = raw;
    slots = (m_exc_count > EXC_SLOTS) ? EXC_SLOTS : m_exc_count;
    if (slots > 4) slots = 4;
    // exception bytes skip folding and filtering
    for (int i = 0; i < slots; i++)
      if (m_exc_chars[8*i +: 8] == raw) return 1'b1;
    if (m_mode == MODE_FOLD || m_mode == MODE_ASCII || m_mode == MODE_ASCII_NS) begin
      c = fold_accent(raw, 1'b1);
      if (c < 8'd32 || c > 8'd126) return 1'b0;
      if (m_mode == MODE_FOLD) return 1'b1;
      if (m_mode == MODE_ASCII_NS && c == "/") return 1'b0;
      if (!m_lyric && c inside {"(", ")", "{", "}", ",", "\\", ":", "\""}) return 1'b0;
      if (m_phrase && !is_alnum_byte(c)) return 1'b0;
      return 1'b1;
    end
    if (m_mode == MODE_EXT) begin
      c = fold_accent(raw, 1'b0);
      return ext_table_hit(c);
    end
    return 1'b1;
  endfunction

  // expected output items for one accepted input item
  function automatic void predict_escape(input logic [7:0] raw, input logic last_byte);
    logic [7:0]  c;
    logic [47:0] text;
    int          len;
    escaped_t    batch [7];
    int          nb;
    nb = 0;
    if (!m_stopped && filter_keeps(raw, c)) begin
      // entity text is right aligned, byte k of len counts from the left
      text = {40'h0, c};
      len  = 1;
      case (c)
        "\"":    begin text = "&quot;"; len = 6; end
        "'":     begin text = "&apos;"; len = 6; end
        "<":     begin text = "&lt;";   len = 4; end
        ">":     begin text = "&gt;";   len = 4; end
        "&":     begin text = "&amp;";  len = 5; end
        default: ;
      endcase
      // the whole expansion plus the terminator slot has to fit
      if (m_emitted + len + 1 > m_max_len) begin
        m_stopped = 1'b1;
      end else begin
        for (int k = 0; k < len; k++) begin
          batch[nb]            = '0;
          batch[nb].out_byte   = text[8*(len-1-k) +: 8];
          batch[nb].byte_valid = 1'b1;
          nb++;
        end
        m_emitted += len;
      end
    end
    if (last_byte) begin
      batch[nb]             = '0;
      batch[nb].string_done = 1'b1;
      batch[nb].truncated   = m_stopped;
      nb++;
      m_emitted = 0;
      m_stopped = 1'b0;
    end
    if (nb > 0) batch[nb-1].run_last = 1'b1;
    for (int k = 0; k < nb; k++) escaped_q.push_back(batch[k]);
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  function automatic void log_mismatch(input string what, input escaped_t want,
                                       input escaped_t got);
    fail_count++;
    if (fail_count <= MAX_SHOWN)
      $display("%0t %s: expected byte %02h valid %b last %b done %b trunc %b, got byte %02h valid %b last %b done %b trunc %b",
               $time, what, want.out_byte, want.byte_valid, want.run_last,
               want.string_done, want.truncated, got.out_byte, got.byte_valid,
               got.run_last, got.string_done, got.truncated);
  endfunction

  function automatic void check_escaped(input escaped_t got);
    escaped_t want;
    if (escaped_q.size() == 0) begin
      log_mismatch("unexpected item", '0, got);
      return;
    end
    want = escaped_q.pop_front();
    if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
        got.run_last !== want.run_last || got.string_done !== want.string_done ||
        got.truncated !== want.truncated)
      log_mismatch("item mismatch", want, got);
  endfunction

  // receiver: random stall per item, long hold-off on request
  initial begin : result_sink
    int       gap;
    escaped_t got;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = rx_calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      if (rx_hold) begin
        out_ch.ready <= 1'b0;
        while (rx_hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.out_byte    = out_ch.out_byte;
      got.byte_valid  = out_ch.byte_valid;
      got.run_last    = out_ch.run_last;
      got.string_done = out_ch.string_done;
      got.truncated   = out_ch.truncated;
      check_escaped(got);
    end
  end

  // long receiver hold-off, counted here so the sender keeps offering items
  initial begin : hold_timer
    forever begin
      @(hold_start);
      rx_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rx_hold = 1'b0;
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one item after a random gap, predict once it is taken
  task automatic send_char(input logic [7:0] c, input logic last_byte);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.char_in    <= c;
    in_ch.string_end <= last_byte;
    do @(posedge clk); while (!in_ch.ready);
    predict_escape(c, last_byte);
  endtask

  // stop offering, wait for every expected item, then let the pipe drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (escaped_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // writes all six registers back to back; block must be idle
  task automatic write_config(input logic [2:0] mode, input logic lyric,
                              input logic phrase, input logic [7:0] max_len,
                              input logic [31:0] exc, input logic [2:0] exc_n);
    logic [2:0]  idx  [6];
    logic [31:0] vals [6];
    idx[0] = REG_FILTER_MODE; vals[0] = {29'd0, mode};
    idx[1] = REG_IS_LYRIC;    vals[1] = {31'd0, lyric};
    idx[2] = REG_IS_PHRASE;   vals[2] = {31'd0, phrase};
    idx[3] = REG_MAX_LENGTH;  vals[3] = {24'd0, max_len};
    idx[4] = REG_EXC_CHARS;   vals[4] = exc;
    idx[5] = REG_EXC_COUNT;   vals[5] = {29'd0, exc_n};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we      <= 1'b0;
    m_mode      = mode;
    m_lyric     = lyric;
    m_phrase    = phrase;
    m_max_len   = max_len;
    m_exc_chars = exc;
    m_exc_count = exc_n;
  endtask

  // one of the bytes that turn into entities, or a slash
  function automatic logic [7:0] entity_char();
    case ($urandom_range(0, 5))
      0:       return "\"";
      1:       return "'";
      2:       return "<";
      3:       return ">";
      4:       return "&";
      default: return "/";
    endcase
  endfunction

  // byte mix: printable, entities, accented, upper half, controls, anything
  function automatic logic [7:0] pick_char();
    int unsigned r;
    case ($urandom_range(0, 5))
      0:       r = $urandom_range(32, 126);
      1:       r = entity_char();
      2:       r = $urandom_range(192, 255);
      3:       r = $urandom_range(128, 191);
      4:       r = $urandom_range(0, 31);
      default: r = $urandom_range(0, 255);
    endcase
    return r[7:0];
  endfunction

  task automatic send_random_string(input int max_chars);
    int len;
    len = $urandom_range(1, max_chars);
    for (int i = 0; i < len; i++)
      send_char(pick_char(), i == len - 1);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // register reset values: slash dropped, lyric punctuation kept, entities escaped
  task automatic test_reset_defaults();
    send_char("<", 1'b0);
    send_char("&", 1'b0);
    send_char("\"", 1'b0);
    send_char("/", 1'b0);
    send_char("(", 1'b0);
    send_char("A", 1'b1);
    settle();
  endtask

  // full folding, then only printable ascii survives
  task automatic test_fold_only();
    write_config(MODE_FOLD, 1'b1, 1'b0, 8'd255, 32'h0, 3'd0);
    send_char(8'd0, 1'b0);
    send_char(8'd255, 1'b0);
    send_char(8'd200, 1'b0);
    send_char(8'd127, 1'b0);
    send_char("'", 1'b1);
    settle();
  endtask

  // ascii filter without lyric punctuation and with phrase rules
  task automatic test_ascii_filter();
    write_config(MODE_ASCII, 1'b0, 1'b1, 8'd64, 32'h0, 3'd0);
    send_char("(", 1'b0);
    send_char("/", 1'b0);
    send_char("9", 1'b1);
    settle();
  endtask

  // partial folding and the extended allow list
  task automatic test_ext_table();
    write_config(MODE_EXT, 1'b1, 1'b0, 8'd64, 32'h0, 3'd0);
    send_char(8'd213, 1'b0);
    send_char(8'd200, 1'b0);
    send_char(8'd96, 1'b0);
    send_char(">", 1'b1);
    settle();
  endtask

  // modes above four behave as no filter
  task automatic test_raw_modes();
    write_config(MODE_RAW_TOP, 1'b0, 1'b1, 8'd16, 32'h0, 3'd0);
    send_char(8'd10, 1'b0);
    send_char(8'd0, 1'b1);
    settle();
  endtask

  // exceptions bypass folding and filtering; oversized count is clamped
  task automatic test_exceptions();
    write_config(MODE_ASCII, 1'b0, 1'b1, 8'd32, {8'd0, "<", 8'd255, 8'd7}, 3'd7);
    send_char(8'd7, 1'b0);
    send_char(8'd255, 1'b0);
    send_char("<", 1'b0);
    send_char(8'd0, 1'b1);
    settle();
  endtask

  // zero length limit stops at once; a limit of two fits exactly one byte
  task automatic test_length_limit();
    write_config(MODE_RAW, 1'b1, 1'b0, 8'd0, 32'h0, 3'd0);
    send_char("a", 1'b1);
    settle();
    write_config(MODE_RAW, 1'b1, 1'b0, 8'd2, 32'h0, 3'd0);
    send_char("a", 1'b0);
    send_char("b", 1'b1);
    settle();
  endtask

  // random register settings with random strings, extremes in the first phases
  task automatic test_random_phases();
    int unsigned r;
    logic [2:0]  mode;
    logic [7:0]  max_len;
    logic [31:0] exc;
    int          items;
    int          len;
    for (int p = 0; p < 8; p++) begin
      r    = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
      mode = r[2:0];
      case (p)
        0:       r = 255;
        1:       r = 0;
        default: begin
          case ($urandom_range(0, 2))
            0:       r = $urandom_range(1, 16);
            1:       r = $urandom_range(17, 64);
            default: r = $urandom_range(0, 255);
          endcase
        end
      endcase
      max_len = r[7:0];
      exc     = {pick_char(), pick_char(), pick_char(), pick_char()};
      r       = $urandom_range(0, 7);
      write_config(mode, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), max_len,
                   exc, r[2:0]);
      // count by characters sent, not strings
      items = 0;
      while (items < 12) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
          send_char(pick_char(), i == len - 1);
        items += len;
      end
      settle();
    end
  endtask

  // receiver holds off while the sender streams entity-heavy text
  task automatic test_backpressure();
    logic [7:0] c;
    write_config(MODE_RAW, 1'b1, 1'b0, 8'd255, 32'h0, 3'd0);
    tx_calm = 1'b1;
    -> hold_start;
    // long string, mostly entity bytes, with a 255 byte limit
    for (int i = 0; i < 60; i++) begin
      c = ($urandom_range(0, 3) != 0) ? entity_char() : pick_char();
      send_char(c, i == 59);
    end
    tx_calm = 1'b0;
    // sender pauses until every result is back
    settle();
    for (int i = 0; i < 3; i++) send_random_string(10);
    settle();
  endtask

  // a stretch with no idling on either side
  task automatic test_no_idle();
    write_config(MODE_FOLD, 1'b0, 1'b0, 8'd40, {4{pick_char()}}, 3'd2);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    for (int i = 0; i < 3; i++) send_random_string(10);
    settle();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_FILTER_MODE;
    cfg_wdata        <= 32'h0;
    in_ch.valid      <= 1'b0;
    in_ch.char_in    <= 8'h00;
    in_ch.string_end <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // register values after reset
    m_mode      = MODE_ASCII_NS;
    m_lyric     = 1'b1;
    m_phrase    = 1'b0;
    m_max_len   = 8'd48;
    m_exc_chars = 32'h0;
    m_exc_count = 3'd0;
    m_emitted   = 0;
    m_stopped   = 1'b0;

    test_reset_defaults();
    test_fold_only();
    test_ascii_filter();
    test_ext_table();
    test_raw_modes();
    test_exceptions();
    test_length_limit();
    test_random_phases();
    test_backpressure();
    test_no_idle();
    settle();

    if (fail_count == 0 && escaped_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
